@@ hw/rtl/tjd_pkg.sv @@
// Package for the touch joystick deflection block.
// Holds the widths, command codes, register indexes and scaling constants.
// No dependencies.
`default_nettype none

package tjd_pkg;

    localparam int COORD_WIDTH_DEF = 12;
    localparam int CMD_W           = 2;
    localparam int CFG_IDX_W       = 3;
    localparam int DEFLECT_W       = 11;
    localparam int DEFLECT_FULL    = 1000;
    localparam int QUOT_W          = 11;
    localparam int STEP_W          = $clog2(QUOT_W);

    localparam logic [CMD_W-1:0] CMD_PRESS   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MOVE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_AREA_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_CENTER = 3'd4;

endpackage

`default_nettype wire

@@ hw/rtl/touch_joystick_deflection.sv @@
// Top level of the touch joystick deflection block.
// Uses tjd_pkg; one shared restoring divider serves both axes in turn.
//
// Channel   Direction  Handshake             Contents
// in        input      in_valid / in_stall   cmd, point_x, point_y
// out       output     out_valid / out_stall handled, moved, deflect_x, deflect_y, engaged
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A press, or a move while engaged, works out both axes in turn before the result word:
// each axis passes through a multiply (S_LOAD), a range check (S_CHECK), eleven divider steps
// (S_DIV) and a store (S_AXIS), and the result register loads after the second axis is stored
// and the output is free. A saturating axis skips its divider steps; other words finish in S_IDLE.
// Reset clears the engaged state, the stored deflection and the config registers to defaults.
// A new word is taken only when the block is idle and the result register can be loaded.
`default_nettype none

module touch_joystick_deflection #(
    parameter int COORD_WIDTH = tjd_pkg::COORD_WIDTH_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire  [tjd_pkg::CMD_W-1:0]           cmd,
    input  wire  [COORD_WIDTH-1:0]              point_x,
    input  wire  [COORD_WIDTH-1:0]              point_y,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic                                handled,
    output logic                                moved,
    output logic signed [tjd_pkg::DEFLECT_W-1:0] deflect_x,
    output logic signed [tjd_pkg::DEFLECT_W-1:0] deflect_y,
    output logic                                engaged,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [tjd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [COORD_WIDTH-1:0]              cfg_data
);
    import tjd_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int PW = CW + 11;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_CHECK = 5'b00100,
        S_DIV   = 5'b01000,
        S_AXIS  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;
    logic   axis_reg, axis_next;
    logic   active_reg, active_next;
    logic   out_valid_reg, out_valid_next;
    logic   [CW-1:0] left_reg, top_reg, width_reg, height_reg;
    logic   center_reg;
    logic signed [DEFLECT_W-1:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;

    logic   [CW-1:0]     px_reg, py_reg;
    logic   [PW-1:0]     rem_reg, rem_next, dvs_reg, dvs_next;
    logic   [QUOT_W-1:0] quot_reg, quot_next;
    logic   [STEP_W-1:0] step_reg, step_next;
    logic                neg_reg, neg_next;
    logic signed [DEFLECT_W-1:0] nx_reg, nx_next, ny_reg, ny_next;
    logic                handled_reg, handled_next, moved_reg, moved_next, engaged_reg, engaged_next;
    logic signed [DEFLECT_W-1:0] dx_reg, dx_next, dy_reg, dy_next;

    logic                accept, out_free;
    logic [CW-1:0]       point_cur, edge_cur, size_cur;
    logic [CW-2:0]       half_raw, half_eff;
    logic [CW:0]         centre;
    logic [CW+1:0]       diff;
    logic [CW:0]         diff_abs;
    logic [PW-1:0]       prod, limit, ge_sub;
    logic                ge;
    logic [QUOT_W-1:0]   qmag;
    logic signed [DEFLECT_W-1:0] axis_val;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || done_reg || !out_free;
    assign accept    = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign handled   = handled_reg;
    assign moved     = moved_reg;
    assign deflect_x = dx_reg;
    assign deflect_y = dy_reg;
    assign engaged   = engaged_reg;

    assign point_cur = axis_reg ? py_reg : px_reg;
    assign edge_cur  = axis_reg ? top_reg : left_reg;
    assign size_cur  = axis_reg ? height_reg : width_reg;
    assign half_raw  = size_cur[CW-1:1];
    assign half_eff  = (half_raw == '0) ? (CW-1)'(1) : half_raw;
    assign centre    = (CW+1)'(edge_cur) + (CW+1)'(half_raw);
    assign diff      = (CW+2)'(point_cur) - (CW+2)'(centre);
    assign diff_abs  = diff[CW+1] ? (CW+1)'(~diff + (CW+2)'(1)) : diff[CW:0];
    assign prod      = PW'(diff_abs) * PW'(DEFLECT_FULL);
    assign limit     = PW'(half_eff) << QUOT_W;
    assign ge        = rem_reg >= dvs_reg;
    assign ge_sub    = rem_reg - dvs_reg;
    assign qmag      = (quot_reg > QUOT_W'(DEFLECT_FULL)) ? QUOT_W'(DEFLECT_FULL) : quot_reg;
    assign axis_val  = neg_reg ? -$signed(qmag) : $signed(qmag);

    always_comb
    begin
        state_next     = state_reg;
        done_next      = done_reg;
        axis_next      = axis_reg;
        active_next    = active_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        out_valid_next = out_valid_reg && out_stall;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        quot_next      = quot_reg;
        step_next      = step_reg;
        neg_next       = neg_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        handled_next   = handled_reg;
        moved_next     = moved_reg;
        engaged_next   = engaged_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (done_reg && out_free)
                begin
                    done_next      = 1'b0;
                    out_valid_next = 1'b1;
                    handled_next   = 1'b1;
                    moved_next     = (nx_reg != pos_x_reg) || (ny_reg != pos_y_reg);
                    pos_x_next     = nx_reg;
                    pos_y_next     = ny_reg;
                    dx_next        = nx_reg;
                    dy_next        = ny_reg;
                    engaged_next   = active_reg;
                end
                else if (accept)
                begin
                    handled_next = 1'b0;
                    moved_next   = 1'b0;
                    dx_next      = pos_x_reg;
                    dy_next      = pos_y_reg;
                    engaged_next = active_reg;
                    case (cmd)
                        CMD_PRESS:
                        begin
                            active_next = 1'b1;
                            axis_next   = 1'b0;
                            state_next  = S_LOAD;
                        end
                        CMD_MOVE:
                        begin
                            if (active_reg)
                            begin
                                axis_next  = 1'b0;
                                state_next = S_LOAD;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                            end
                        end
                        CMD_RELEASE:
                        begin
                            out_valid_next = 1'b1;
                            if (active_reg)
                            begin
                                active_next  = 1'b0;
                                engaged_next = 1'b0;
                                handled_next = 1'b1;
                                if (center_reg && (pos_x_reg != '0 || pos_y_reg != '0))
                                begin
                                    pos_x_next = '0;
                                    pos_y_next = '0;
                                    dx_next    = '0;
                                    dy_next    = '0;
                                    moved_next = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                rem_next   = prod;
                neg_next   = diff[CW+1];
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (rem_reg >= limit)
                begin
                    quot_next  = '1;
                    state_next = S_AXIS;
                end
                else
                begin
                    quot_next  = '0;
                    dvs_next   = PW'(half_eff) << (QUOT_W - 1);
                    step_next  = STEP_W'(QUOT_W - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (ge)
                begin
                    rem_next = ge_sub;
                end
                quot_next = {quot_reg[QUOT_W-2:0], ge};
                dvs_next  = dvs_reg >> 1;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = S_AXIS;
                end
            end
            S_AXIS:
            begin
                if (!axis_reg)
                begin
                    nx_next    = axis_val;
                    axis_next  = 1'b1;
                    state_next = S_LOAD;
                end
                else
                begin
                    ny_next    = axis_val;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            axis_reg      <= 1'b0;
            active_reg    <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
            top_reg       <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            center_reg    <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            axis_reg      <= axis_next;
            active_reg    <= active_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_AREA_LEFT:   left_reg   <= cfg_data;
                    CFG_AREA_TOP:    top_reg    <= cfg_data;
                    CFG_AREA_WIDTH:  width_reg  <= cfg_data;
                    CFG_AREA_HEIGHT: height_reg <= cfg_data;
                    CFG_SELF_CENTER: center_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= point_x;
            py_reg <= point_y;
        end
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        quot_reg    <= quot_next;
        step_reg    <= step_next;
        neg_reg     <= neg_next;
        nx_reg      <= nx_next;
        ny_reg      <= ny_next;
        handled_reg <= handled_next;
        moved_reg   <= moved_next;
        engaged_reg <= engaged_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
    end

`ifndef SYNTHESIS
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (dx_reg <= 11'sd1000 && dx_reg >= -11'sd1000 &&
                       dy_reg <= 11'sd1000 && dy_reg >= -11'sd1000))
        else $error("Deflection word out of range.");
    a_moved: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (handled || !moved))
        else $error("Unhandled word reports a change.");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (out_valid_reg || state_reg != S_IDLE))
        else $error("Accepted word produced no work.");
    a_center: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && moved && !engaged) |-> (dx_reg == '0 && dy_reg == '0))
        else $error("Release changed the deflection to a nonzero value.");
`endif

endmodule

`default_nettype wire
